FILE: design/iaae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iaae_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    // CORDIC datapath width and angle accumulator width (1/4096 centidegree)
    localparam int DW = 37;
    localparam int ZW = 28;
    localparam int TAB_IW = 5;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_ROTV  = 2'd1;
    localparam logic [1:0] KIND_GYRO  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_HEEL_OFS  = 2'd1;
    localparam logic [1:0] REG_PITCH_OFS = 2'd2;

    localparam logic signed [ZW-1:0] ANG_90    = 28'sd36864000;
    localparam logic signed [20:0]   RATE_GAIN = 21'sd733386;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] r;
        logic [7:0]         status;
        logic               active;
    } item_t;

    typedef struct packed {
        logic signed [15:0] heel_ofs;
        logic signed [15:0] pitch_ofs;
    } cfg_t;

    // atan(2^-i) in 1/4096 centidegree
    function automatic logic [24:0] atan_entry(input logic [TAB_IW-1:0] idx);
        logic [24:0] v;
        case (idx)
            5'd0:  v = 25'd18432000;
            5'd1:  v = 25'd10881045;
            5'd2:  v = 25'd5749245;
            5'd3:  v = 25'd2918407;
            5'd4:  v = 25'd1464867;
            5'd5:  v = 25'd733147;
            5'd6:  v = 25'd366663;
            5'd7:  v = 25'd183343;
            5'd8:  v = 25'd91673;
            5'd9:  v = 25'd45837;
            5'd10: v = 25'd22918;
            5'd11: v = 25'd11459;
            5'd12: v = 25'd5730;
            5'd13: v = 25'd2865;
            5'd14: v = 25'd1432;
            5'd15: v = 25'd716;
            5'd16: v = 25'd358;
            5'd17: v = 25'd179;
            5'd18: v = 25'd90;
            5'd19: v = 25'd45;
            5'd20: v = 25'd22;
            5'd21: v = 25'd11;
            5'd22: v = 25'd6;
            5'd23: v = 25'd3;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/iaae_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module iaae_cordic #(
    parameter int CORDIC_STEPS = iaae_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [iaae_pkg::DW-1:0]  x_in,
    input  wire logic signed [iaae_pkg::DW-1:0]  y_in,
    output logic                                 done,
    output logic signed [15:0]                   angle
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam int DW = iaae_pkg::DW;
    localparam int ZW = iaae_pkg::ZW;
    localparam int TAB_IW = iaae_pkg::TAB_IW;
    localparam logic signed [ZW-1:0] ANG_MAX = ZW'(18000);
    localparam logic signed [ZW-1:0] HALF_LSB = ZW'(2048);

    logic                 busy_reg, busy_next;
    logic                 zero_reg, zero_next;
    logic                 done_reg, done_next;
    logic [SW-1:0]        i_reg, i_next;
    logic signed [DW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [15:0]   angle_reg, angle_next;

    logic signed [DW-1:0] dx, dy;
    logic signed [ZW-1:0] tab, zr, c;

    always_comb
    begin
        busy_next  = busy_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        i_next     = i_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        angle_next = angle_reg;
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        tab = $signed({3'b000, iaae_pkg::atan_entry(TAB_IW'(i_reg))});
        zr  = z_reg + HALF_LSB;
        c   = zr >>> 12;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            // prerotate left half plane by 90 degrees
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = iaae_pkg::ANG_90;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -iaae_pkg::ANG_90;
                end
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (i_reg == SW'(CORDIC_STEPS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    angle_next = '0;
                else if (c > ANG_MAX)
                    angle_next = 16'sd18000;
                else if (c < -ANG_MAX)
                    angle_next = -16'sd18000;
                else
                    angle_next = c[15:0];
            end
            else
            begin
                i_next = i_reg + 1'b1;
                if (y_reg > 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + tab;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - tab;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg  <= zero_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule
`default_nettype wire

FILE: design/iaae_front.sv
`timescale 1ns / 1ps
`default_nettype none
module iaae_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         report_kind,
    input  wire logic signed [15:0] comp_x,
    input  wire logic signed [15:0] comp_y,
    input  wire logic signed [15:0] comp_z,
    input  wire logic signed [15:0] comp_real,
    input  wire logic [7:0]         report_status,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    q_valid,
    input  wire logic               q_pop,
    output iaae_pkg::item_t         q_item,
    output iaae_pkg::cfg_t          cfg
);
    logic               enabled_reg;
    logic signed [15:0] heel_ofs_reg, pitch_ofs_reg;

    iaae_pkg::item_t    fifo_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg, count_next;
    logic               accept, take;
    iaae_pkg::item_t    in_item;

    assign full    = (count_reg == 2'd2);
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign take    = q_pop && q_valid;
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign cfg.heel_ofs  = heel_ofs_reg;
    assign cfg.pitch_ofs = pitch_ofs_reg;

    // classify: only enabled, known kinds touch the record
    always_comb
    begin
        in_item.kind   = report_kind;
        in_item.x      = comp_x;
        in_item.y      = comp_y;
        in_item.z      = comp_z;
        in_item.r      = comp_real;
        in_item.status = report_status;
        in_item.active = enabled_reg && (report_kind != iaae_pkg::KIND_OTHER);
        count_next     = count_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            heel_ofs_reg  <= '0;
            pitch_ofs_reg <= '0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    iaae_pkg::REG_ENABLED:   enabled_reg   <= cfg_data[0];
                    iaae_pkg::REG_HEEL_OFS:  heel_ofs_reg  <= cfg_data;
                    iaae_pkg::REG_PITCH_OFS: pitch_ofs_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (take)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fifo_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

FILE: design/iaae_back.sv
`timescale 1ns / 1ps
`default_nettype none
module iaae_back #(
    parameter int CORDIC_STEPS = iaae_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire iaae_pkg::item_t    q_item,
    input  wire iaae_pkg::cfg_t     cfg,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      heel,
    output logic signed [15:0]      pitch,
    output logic [15:0]             heading,
    output logic [1:0]              accuracy,
    output logic signed [19:0]      roll_rate,
    output logic signed [19:0]      pitch_rate,
    output logic signed [19:0]      yaw_rate,
    output logic                    updated
);
    localparam int DW = iaae_pkg::DW;
    localparam int ROOT_W = 30;
    localparam int RAD_W = 2 * ROOT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SQRT  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_CORD  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    iaae_pkg::item_t      item_reg, item_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 phase_reg, phase_next;
    logic signed [DW-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic signed [19:0]   rt_reg [3];
    logic signed [19:0]   rt_next [3];
    logic [ROOT_W:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic signed [15:0]   h_reg, h_next, p_reg, p_next, hd_reg, hd_next;

    logic signed [15:0]   heel_reg, heel_next, pitch_reg, pitch_next;
    logic [15:0]          heading_reg, heading_next;
    logic [1:0]           acc_reg, acc_next;
    logic signed [19:0]   rate_reg [3];
    logic signed [19:0]   rate_next [3];
    logic                 upd_reg, upd_next;
    logic                 out_valid_reg, out_valid_next;

    logic signed [15:0]   mul_a;
    logic signed [20:0]   mul_b;
    logic signed [DW-1:0] prod, acc_sum, rsum;
    logic [ROOT_W+2:0]    rem_t, trial;
    logic                 cord_start, cord_done;
    logic signed [DW-1:0] cord_x, cord_y;
    logic signed [15:0]   cord_angle;
    logic [16:0]          hd_wrapped;

    function automatic logic signed [15:0] wrap180(input logic signed [15:0] a,
                                                   input logic signed [15:0] ofs);
        logic signed [17:0] d;
        d = 18'(a) - 18'(ofs);
        if (d > 18'sd18000)
            d = d - 18'sd36000;
        else if (d < -18'sd18000)
            d = d + 18'sd36000;
        return d[15:0];
    endfunction

    iaae_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (cord_x),
        .y_in  (cord_y),
        .done  (cord_done),
        .angle (cord_angle)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = item_reg.x;
        mul_b = 21'(item_reg.x);
        case (item_reg.kind)
            iaae_pkg::KIND_ACCEL:
            begin
                mul_a = (cnt_reg[0]) ? item_reg.y : item_reg.x;
                mul_b = 21'(mul_a);
            end
            iaae_pkg::KIND_ROTV:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a = item_reg.r;
                        mul_b = 21'(item_reg.z);
                    end
                    2'd1:
                    begin
                        mul_a = item_reg.x;
                        mul_b = 21'(item_reg.y);
                    end
                    2'd2:
                    begin
                        mul_a = item_reg.y;
                        mul_b = 21'(item_reg.y);
                    end
                    default:
                    begin
                        mul_a = item_reg.z;
                        mul_b = 21'(item_reg.z);
                    end
                endcase
            end
            iaae_pkg::KIND_GYRO:
            begin
                case (cnt_reg[1:0])
                    2'd0:    mul_a = item_reg.x;
                    2'd1:    mul_a = item_reg.y;
                    default: mul_a = item_reg.z;
                endcase
                mul_b = iaae_pkg::RATE_GAIN;
            end
            default: ;
        endcase
    end

    assign prod = $signed({{21{mul_a[15]}}, mul_a} * {{16{mul_b[20]}}, mul_b});
    assign acc_sum = acc_a_reg + prod;
    assign rsum = prod + DW'(32768);
    assign rem_t = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign hd_wrapped = (hd_reg < 0) ? 17'(hd_reg) + 17'd36000 : 17'(hd_reg);

    always_comb
    begin
        cord_x = {{7{item_reg.x[15]}}, item_reg.x, 14'd0};
        cord_y = {{7{item_reg.y[15]}}, item_reg.y, 14'd0};
        if (item_reg.kind == iaae_pkg::KIND_ROTV)
        begin
            cord_y = {acc_a_reg[DW-2:0], 1'b0};
            cord_x = DW'(1 << 28) - {acc_b_reg[DW-2:0], 1'b0};
        end
        else if (phase_reg)
        begin
            cord_y = -$signed({{7{item_reg.z[15]}}, item_reg.z, 14'd0});
            cord_x = {7'd0, root_reg};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        rt_next        = rt_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        rad_next       = rad_reg;
        h_next         = h_reg;
        p_next         = p_reg;
        hd_next        = hd_reg;
        heel_next      = heel_reg;
        pitch_next     = pitch_reg;
        heading_next   = heading_reg;
        acc_next       = acc_reg;
        rate_next      = rate_reg;
        upd_next       = upd_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        cord_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    acc_a_next = '0;
                    acc_b_next = '0;
                    state_next = q_item.active ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (item_reg.kind)
                    iaae_pkg::KIND_ACCEL:
                    begin
                        acc_a_next = acc_sum;
                        if (cnt_reg[0])
                        begin
                            rad_next   = {acc_sum[31:0], 28'd0};
                            rem_next   = '0;
                            root_next  = '0;
                            cnt_next   = '0;
                            state_next = S_SQRT;
                        end
                    end
                    iaae_pkg::KIND_ROTV:
                    begin
                        if (!cnt_reg[1])
                            acc_a_next = acc_sum;
                        else
                            acc_b_next = acc_b_reg + prod;
                        if (cnt_reg[1:0] == 2'd3)
                            state_next = S_START;
                    end
                    default:
                    begin
                        case (cnt_reg[1:0])
                            2'd0:    rt_next[0] = rsum[35:16];
                            2'd1:    rt_next[1] = rsum[35:16];
                            default: rt_next[2] = rsum[35:16];
                        endcase
                        if (cnt_reg[1:0] == 2'd2)
                            state_next = S_DONE;
                    end
                endcase
            end
            S_SQRT:
            begin
                // one root bit per cycle
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_t >= trial)
                begin
                    rem_next  = (ROOT_W+1)'(rem_t - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(ROOT_W - 1))
                    state_next = S_START;
            end
            S_START:
            begin
                cord_start = 1'b1;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    if (item_reg.kind == iaae_pkg::KIND_ROTV)
                    begin
                        hd_next    = cord_angle;
                        state_next = S_DONE;
                    end
                    else if (!phase_reg)
                    begin
                        h_next     = cord_angle;
                        phase_next = 1'b1;
                        state_next = S_START;
                    end
                    else
                    begin
                        p_next     = cord_angle;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                // hold until the result slot is free
                if (!out_valid_reg || pop)
                begin
                    if (item_reg.active)
                    begin
                        case (item_reg.kind)
                            iaae_pkg::KIND_ACCEL:
                            begin
                                heel_next  = wrap180(h_reg, cfg.heel_ofs);
                                pitch_next = wrap180(p_reg, cfg.pitch_ofs);
                            end
                            iaae_pkg::KIND_ROTV:
                            begin
                                heading_next = hd_wrapped[15:0];
                                acc_next     = item_reg.status[1:0];
                            end
                            default:
                                rate_next = rt_reg;
                        endcase
                    end
                    upd_next       = item_reg.active;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            heel_reg      <= '0;
            pitch_reg     <= '0;
            heading_reg   <= '0;
            acc_reg       <= '0;
            rate_reg      <= '{default: '0};
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            heel_reg      <= heel_next;
            pitch_reg     <= pitch_next;
            heading_reg   <= heading_next;
            acc_reg       <= acc_next;
            rate_reg      <= rate_next;
            upd_reg       <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        rt_reg    <= rt_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        rad_reg   <= rad_next;
        h_reg     <= h_next;
        p_reg     <= p_next;
        hd_reg    <= hd_next;
    end

    assign empty      = !out_valid_reg;
    assign heel       = heel_reg;
    assign pitch      = pitch_reg;
    assign heading    = heading_reg;
    assign accuracy   = acc_reg;
    assign roll_rate  = rate_reg[0];
    assign pitch_rate = rate_reg[1];
    assign yaw_rate   = rate_reg[2];
    assign updated    = upd_reg;

endmodule
`default_nettype wire

FILE: design/imu_attitude_angle_engine.sv
// IMU attitude engine: one sensor report in, one copy of the held attitude record out.
// Input side is a queue: drive the report fields with push; the item is taken on a
// clock edge where push is high and full is low. A two-entry queue sits in front.
// Result side is a queue: while empty is low the record (heel, pitch, heading,
// accuracy, three rates, updated) is on the ports; pop takes it.
// Configuration: cfg_write with cfg_index 0 (enabled), 1 (heel offset), 2 (pitch
// offset) and cfg_data; write only while no item is in flight.
// Each item is worked by the back-end sequencer with one shared multiplier and one
// CORDIC unit: gyroscope items use the multiplier only, rotation vector items the
// multiplier and one CORDIC pass, accelerometer items the multiplier, a bit-serial
// square root and two CORDIC passes; ignored items skip straight to the result.
// Items are worked one at a time; the next one is taken off the queue as soon as
// the previous result is placed in the result register.
// When the receiver stalls, one result waits on the ports, the back end finishes
// the next item and holds it, and the input queue then fills and raises full.
// Reset clears configuration, the record and both queues.
`timescale 1ns / 1ps
`default_nettype none
module imu_attitude_angle_engine #(
    parameter int CORDIC_STEPS = iaae_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         report_kind,
    input  wire logic signed [15:0] comp_x,
    input  wire logic signed [15:0] comp_y,
    input  wire logic signed [15:0] comp_z,
    input  wire logic signed [15:0] comp_real,
    input  wire logic [7:0]         report_status,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      heel,
    output logic signed [15:0]      pitch,
    output logic [15:0]             heading,
    output logic [1:0]              accuracy,
    output logic signed [19:0]      roll_rate,
    output logic signed [19:0]      pitch_rate,
    output logic signed [19:0]      yaw_rate,
    output logic                    updated,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    logic            q_valid, q_pop;
    iaae_pkg::item_t q_item;
    iaae_pkg::cfg_t  cfg;

    iaae_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .report_kind   (report_kind),
        .comp_x        (comp_x),
        .comp_y        (comp_y),
        .comp_z        (comp_z),
        .comp_real     (comp_real),
        .report_status (report_status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .cfg           (cfg)
    );

    iaae_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .cfg        (cfg),
        .empty      (empty),
        .pop        (pop),
        .heel       (heel),
        .pitch      (pitch),
        .heading    (heading),
        .accuracy   (accuracy),
        .roll_rate  (roll_rate),
        .pitch_rate (pitch_rate),
        .yaw_rate   (yaw_rate),
        .updated    (updated)
    );

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

    class attitude_board;
        bit               en;
        int               heel_ofs;
        int               pitch_ofs;
        int               heel_r;
        int               pitch_r;
        int               heading_r;
        int               acc_r;
        int               rate_r[3];
        logic [110:0]     records[$];
        int               errors;

        function new();
            en = 0; heel_ofs = 0; pitch_ofs = 0;
            heel_r = 0; pitch_r = 0; heading_r = 0; acc_r = 0;
            rate_r = '{0, 0, 0};
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == iaae_pkg::REG_ENABLED) en = val[0];
            else if (idx == iaae_pkg::REG_HEEL_OFS) heel_ofs = $signed(val);
            else if (idx == iaae_pkg::REG_PITCH_OFS) pitch_ofs = $signed(val);
        endfunction

        function longint unsigned root64(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function int angle_of(longint y, longint x);
            longint z, t, dx, dy, c;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 36864000;
                end else begin
                    t = x; x = -y; y = t; z = -36864000;
                end
            end
            for (int i = 0; i < iaae_pkg::CORDIC_STEPS_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(iaae_pkg::atan_entry(i[4:0]));
                end else begin
                    x -= dx; y += dy; z -= longint'(iaae_pkg::atan_entry(i[4:0]));
                end
            end
            c = (z + 2048) >>> 12;
            if (c > 18000) c = 18000;
            if (c < -18000) c = -18000;
            return int'(c);
        endfunction

        function int wrap_half_turn(int a);
            while (a > 18000) a -= 36000;
            while (a < -18000) a += 36000;
            return a;
        endfunction

        function void note_item(logic [1:0] kind, logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z, logic signed [15:0] r, logic [7:0] st);
            longint cx, cy, cz, cr, s, c, mag;
            bit upd;
            cx = x; cy = y; cz = z; cr = r;
            upd = 0;
            if (en && kind == iaae_pkg::KIND_ACCEL) begin
                mag = longint'(root64(longint'(cx * cx + cy * cy) << 28));
                heel_r = wrap_half_turn(angle_of(cy * 16384, cx * 16384) - heel_ofs);
                pitch_r = wrap_half_turn(angle_of(-cz * 16384, mag) - pitch_ofs);
                upd = 1;
            end else if (en && kind == iaae_pkg::KIND_ROTV) begin
                s = 2 * (cr * cz + cx * cy);
                c = (longint'(1) << 28) - 2 * (cy * cy + cz * cz);
                heading_r = angle_of(s, c);
                if (heading_r < 0) heading_r += 36000;
                acc_r = st[1:0];
                upd = 1;
            end else if (en && kind == iaae_pkg::KIND_GYRO) begin
                rate_r[0] = int'((cx * 733386 + 32768) >>> 16);
                rate_r[1] = int'((cy * 733386 + 32768) >>> 16);
                rate_r[2] = int'((cz * 733386 + 32768) >>> 16);
                upd = 1;
            end
            records.push_back({heel_r[15:0], pitch_r[15:0], heading_r[15:0], acc_r[1:0],
                               rate_r[0][19:0], rate_r[1][19:0], rate_r[2][19:0], upd});
        endfunction

        function void check_record(logic [110:0] got);
            logic [110:0] want;
            if (records.size() == 0) begin
                $display("%0t: record with none pending, actual %h", $time, got);
                errors++;
                return;
            end
            want = records.pop_front();
            if (want[110:95] !== got[110:95])
                $display("%0t: heel expected %0d actual %0d", $time,
                         $signed(want[110:95]), $signed(got[110:95]));
            if (want[94:79] !== got[94:79])
                $display("%0t: pitch expected %0d actual %0d", $time,
                         $signed(want[94:79]), $signed(got[94:79]));
            if (want[78:63] !== got[78:63])
                $display("%0t: heading expected %0d actual %0d", $time, want[78:63], got[78:63]);
            if (want[62:61] !== got[62:61])
                $display("%0t: accuracy expected %0d actual %0d", $time, want[62:61], got[62:61]);
            if (want[60:41] !== got[60:41])
                $display("%0t: roll_rate expected %0d actual %0d", $time,
                         $signed(want[60:41]), $signed(got[60:41]));
            if (want[40:21] !== got[40:21])
                $display("%0t: pitch_rate expected %0d actual %0d", $time,
                         $signed(want[40:21]), $signed(got[40:21]));
            if (want[20:1] !== got[20:1])
                $display("%0t: yaw_rate expected %0d actual %0d", $time,
                         $signed(want[20:1]), $signed(got[20:1]));
            if (want[0] !== got[0])
                $display("%0t: updated expected %0d actual %0d", $time, want[0], got[0]);
            if (want !== got) errors++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         report_kind;
    logic signed [15:0] comp_x, comp_y, comp_z, comp_real;
    logic [7:0]         report_status;
    logic               empty;
    logic               pop;
    logic signed [15:0] heel, pitch;
    logic [15:0]        heading;
    logic [1:0]         accuracy;
    logic signed [19:0] roll_rate, pitch_rate, yaw_rate;
    logic               updated;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    attitude_board board;
    bit            steady;
    int            cycles;

    imu_attitude_angle_engine u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .report_kind(report_kind), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .comp_real(comp_real), .report_status(report_status),
        .empty(empty), .pop(pop), .heel(heel), .pitch(pitch), .heading(heading),
        .accuracy(accuracy), .roll_rate(roll_rate), .pitch_rate(pitch_rate),
        .yaw_rate(yaw_rate), .updated(updated),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        cycles = 0;
        forever begin
            #5 clk = ~clk;
            if (clk) begin
                cycles++;
                if (cycles > 2000000) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, check the item at negedge before it is taken
    initial begin
        int hold;
        pop = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                pop <= 0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 7);
                pop <= 0;
            end else begin
                pop <= 1;
            end
            @(negedge clk);
            if (pop && !empty)
                board.check_record({heel, pitch, heading, accuracy, roll_rate, pitch_rate,
                                    yaw_rate, updated});
        end
    end

    task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [15:0] r, logic [7:0] st);
        int gap;
        if (!steady && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        report_kind <= kind;
        comp_x <= x; comp_y <= y; comp_z <= z; comp_real <= r;
        report_status <= st;
        forever begin
            @(negedge clk);
            if (!full) break;
        end
        @(posedge clk);
        board.note_item(kind, x, y, z, r, st);
    endtask

    // drop push right at the last accepting edge and wait until all expected records are checked
    task automatic settle();
        push <= 0;
        while (board.records.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 512)) - 256);
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int n);
        logic [1:0] kind;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            kind = (sel < 3) ? iaae_pkg::KIND_ACCEL : (sel < 6) ? iaae_pkg::KIND_ROTV :
                   (sel < 9) ? iaae_pkg::KIND_GYRO : iaae_pkg::KIND_OTHER;
            send_item(kind, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                      8'($urandom));
        end
    endtask

    initial begin
        board = new();
        steady = 0;
        rst_n = 0;
        push = 0; report_kind = iaae_pkg::KIND_ACCEL;
        comp_x = 0; comp_y = 0; comp_z = 0; comp_real = 0; report_status = 0;
        cfg_write = 0; cfg_index = iaae_pkg::REG_ENABLED; cfg_data = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // disabled after reset: hold the record
        send_item(iaae_pkg::KIND_ACCEL, 16'd100, 16'd50, 16'd20, 16'd0, 8'hFF);
        send_item(iaae_pkg::KIND_GYRO, 16'h7FFF, 16'h8000, 16'd5, 16'd0, 8'h00);
        settle();
        write_reg(iaae_pkg::REG_ENABLED, 16'd1);
        write_reg(2'd3, 16'hFFFF);
        send_item(iaae_pkg::KIND_ACCEL, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ACCEL, 16'hFF00, 16'd0, 16'd0, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ACCEL, 16'h8000, 16'h8000, 16'h8000, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ACCEL, 16'd0, 16'd0, 16'h8000, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ACCEL, 16'd2560, 16'h8000, 16'd0, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_ROTV, 16'd0, 16'd0, 16'd0, 16'd16384, 8'h03);
        send_item(iaae_pkg::KIND_ROTV, 16'd0, 16'd0, 16'd0, 16'd0, 8'h02);
        send_item(iaae_pkg::KIND_ROTV, 16'd0, 16'd16384, 16'd0, 16'd0, 8'hFD);
        send_item(iaae_pkg::KIND_ROTV, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 8'hAA);
        send_item(iaae_pkg::KIND_ROTV, 16'd11585, 16'd0, 16'hD2BF, 16'd11585, 8'h01);
        send_item(iaae_pkg::KIND_GYRO, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 8'h00);
        send_item(iaae_pkg::KIND_GYRO, 16'hFFFF, 16'd1, 16'h8000, 16'h7FFF, 8'h00);
        send_item(iaae_pkg::KIND_OTHER, 16'd300, 16'd300, 16'd300, 16'd300, 8'hFF);
        settle();

        write_reg(iaae_pkg::REG_HEEL_OFS, 16'd18000);
        write_reg(iaae_pkg::REG_PITCH_OFS, -16'sd18000);
        random_items(250);
        settle();
        write_reg(iaae_pkg::REG_HEEL_OFS, -16'sd18000);
        write_reg(iaae_pkg::REG_PITCH_OFS, 16'd18000);
        random_items(250);
        settle();
        write_reg(iaae_pkg::REG_HEEL_OFS, 16'h7FFF);
        write_reg(iaae_pkg::REG_PITCH_OFS, 16'h8000);
        random_items(250);
        settle();
        write_reg(iaae_pkg::REG_ENABLED, 16'hFFFE);
        random_items(100);
        settle();
        write_reg(iaae_pkg::REG_ENABLED, 16'd1);
        write_reg(iaae_pkg::REG_HEEL_OFS, 16'd0);
        write_reg(iaae_pkg::REG_PITCH_OFS, 16'd0);
        random_items(300);
        settle();
        write_reg(iaae_pkg::REG_HEEL_OFS, 16'($urandom_range(0, 36000) - 18000));
        write_reg(iaae_pkg::REG_PITCH_OFS, 16'($urandom_range(0, 36000) - 18000));
        random_items(300);
        settle();
        steady = 1;
        random_items(280);

        push <= 0;
        while (board.records.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (board.errors == 0 && board.records.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: imu_attitude_angle_engine.f
design/iaae_pkg.sv
design/iaae_cordic.sv
design/iaae_front.sv
design/iaae_back.sv
design/imu_attitude_angle_engine.sv
bench/tb.sv
